// File: rtl/skl_pkg.sv
// ============================================================================
// skl_pkg
// Shared types and constants of the symmetric KL Gaussian distance block.
// ============================================================================
`default_nettype none

package skl_pkg;

    localparam int unsigned VAL_W   = 32;           // means, variances, floor
    localparam int unsigned DIFF_W  = VAL_W + 1;    // exact mean difference
    localparam int unsigned SQ_W    = 2 * VAL_W;    // squared difference, Q32.32
    localparam int unsigned TOT_W   = 48;           // running total, Q32.16
    localparam int unsigned SUM_W   = TOT_W + 2;    // sum of four clamped parts
    localparam int unsigned ACC_W   = SUM_W + 1;    // total plus term
    localparam int unsigned ITER_W  = 7;            // divider step counter
    localparam int unsigned FRAC_W  = 16;           // Q16.16 fraction bits
    localparam int unsigned PADDR_W = 3;

    localparam logic [VAL_W-1:0]  FLOOR_RESET = 32'd655360;   // 10.0
    localparam logic [TOT_W-1:0]  TOTAL_MAX   = {TOT_W{1'b1}};
    localparam logic [SUM_W-1:0]  TWO_Q16     = 50'd131072;   // 2.0
    localparam logic [ITER_W-1:0] RATIO_ITERS = 7'd48;
    localparam logic [ITER_W-1:0] QUOT_ITERS  = 7'd64;

    // Register index taken from paddr[2].
    localparam logic REG_VARIANCE_FLOOR = 1'b0;

    // Which of the four quotients the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_R1 = 2'd0,   // va / vb
        DIV_R2 = 2'd1,   // vb / va
        DIV_Q1 = 2'd2,   // d^2 / va
        DIV_Q2 = 2'd3    // d^2 / vb
    } div_sel_t;

    typedef struct packed {
        logic     capture;    // latch an accepted item
        logic     take_abs;   // magnitude of the mean difference
        logic     square;     // square the magnitude
        logic     div_start;  // launch the divider
        div_sel_t div_sel;    // operand selection
        logic     div_take;   // add the clamped quotient into the sum
        logic     term;       // subtract 2.0 from the sum
        logic     acc;        // fold the term into the running total
    } skl_cmd_t;

    typedef struct packed {
        logic div_done;   // quotient ready this cycle
        logic last;       // current item closes the vector
        logic out_full;   // result register cannot take a new result
    } skl_status_t;

endpackage : skl_pkg

`default_nettype wire

// File: rtl/skl_div.sv
// ============================================================================
// skl_div
// Restoring radix-2 divider, one quotient bit per cycle, 64 by 32 bits.
// ============================================================================
`default_nettype none

module skl_div
    import skl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   dividend,
    input  wire logic [VAL_W-1:0]  divisor,
    input  wire logic [ITER_W-1:0] iters,
    output logic                   done,
    output logic [SQ_W-1:0]        quotient
);

    // The dividend is consumed from the top; quotient bits enter at the bottom.
    logic [SQ_W-1:0]   dvd_reg, dvd_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  dsr_reg, dsr_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [VAL_W:0]    shifted;
    logic [VAL_W:0]    reduced;
    logic              fits;

    assign shifted = {rem_reg, dvd_reg[SQ_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign reduced = shifted - {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[SQ_W-2:0], fits};
            rem_next = fits ? reduced[VAL_W-1:0] : shifted[VAL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule : skl_div

`default_nettype wire

// File: rtl/skl_dp.sv
// ============================================================================
// skl_dp
// Datapath: operand registers, squarer, shared divider, sum and total.
// ============================================================================
`default_nettype none

module skl_dp
    import skl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire skl_cmd_t         cmd,
    output skl_status_t           status,
    input  wire logic [VAL_W-1:0] floor_val,
    input  wire logic [VAL_W-1:0] mean_a,
    input  wire logic [VAL_W-1:0] var_a,
    input  wire logic [VAL_W-1:0] mean_b,
    input  wire logic [VAL_W-1:0] var_b,
    input  wire logic             last_coeff,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [TOT_W-1:0]      m_tdata,
    output logic                  m_tuser
);

    logic [VAL_W-1:0]  va_reg, vb_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [VAL_W-1:0]  mag_reg;
    logic [SQ_W-1:0]   d2_reg;
    logic              last_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  term_reg;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              sat_reg, sat_next;
    logic              ovalid_reg, ovalid_next;
    logic [TOT_W-1:0]  odata_reg;
    logic              ouser_reg;

    logic [VAL_W-1:0]  floor_eff;
    logic [DIFF_W-1:0] diff_abs;
    logic [SQ_W-1:0]   div_dividend;
    logic [VAL_W-1:0]  div_divisor;
    logic [ITER_W-1:0] div_iters;
    logic              div_done;
    logic [SQ_W-1:0]   div_quot;
    logic [TOT_W-1:0]  part;
    logic [ACC_W-1:0]  acc_sum;
    logic              acc_ovf;
    logic [TOT_W-1:0]  acc_total;
    logic              acc_sat;

    // A zero floor still keeps every divisor nonzero.
    assign floor_eff = (floor_val == '0) ? 32'd1 : floor_val;
    assign diff_abs  = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;

    always_comb begin
        case (cmd.div_sel)
            DIV_R1: begin
                div_dividend = {va_reg, {VAL_W{1'b0}}};
                div_divisor  = vb_reg;
                div_iters    = RATIO_ITERS;
            end
            DIV_R2: begin
                div_dividend = {vb_reg, {VAL_W{1'b0}}};
                div_divisor  = va_reg;
                div_iters    = RATIO_ITERS;
            end
            DIV_Q1: begin
                div_dividend = d2_reg;
                div_divisor  = va_reg;
                div_iters    = QUOT_ITERS;
            end
            default: begin
                div_dividend = d2_reg;
                div_divisor  = vb_reg;
                div_iters    = QUOT_ITERS;
            end
        endcase
    end

    skl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Ratio runs take 48 steps, so only the low 48 bits hold their quotient.
    always_comb begin
        if (cmd.div_sel == DIV_R1 || cmd.div_sel == DIV_R2) begin
            part = div_quot[TOT_W-1:0];
        end else if (div_quot[SQ_W-1:TOT_W] != '0) begin
            part = TOTAL_MAX;
        end else begin
            part = div_quot[TOT_W-1:0];
        end
    end

    assign acc_sum   = {{(ACC_W-TOT_W){1'b0}}, total_reg} + {1'b0, term_reg};
    assign acc_ovf   = acc_sum > {{(ACC_W-TOT_W){1'b0}}, TOTAL_MAX};
    assign acc_total = acc_ovf ? TOTAL_MAX : acc_sum[TOT_W-1:0];
    assign acc_sat   = sat_reg | acc_ovf;

    always_comb begin
        total_next  = total_reg;
        sat_next    = sat_reg;
        ovalid_next = ovalid_reg & ~m_tready;
        if (cmd.acc) begin
            if (last_reg) begin
                total_next  = '0;
                sat_next    = 1'b0;
                ovalid_next = 1'b1;
            end else begin
                total_next = acc_total;
                sat_next   = acc_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            total_reg  <= total_next;
            sat_reg    <= sat_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            va_reg   <= (var_a < floor_eff) ? floor_eff : var_a;
            vb_reg   <= (var_b < floor_eff) ? floor_eff : var_b;
            diff_reg <= {mean_a[VAL_W-1], mean_a} - {mean_b[VAL_W-1], mean_b};
            last_reg <= last_coeff;
        end
        if (cmd.take_abs) begin
            mag_reg <= diff_abs[VAL_W-1:0];
        end
        if (cmd.square) begin
            d2_reg  <= mag_reg * mag_reg;
            sum_reg <= '0;
        end
        if (cmd.div_take) begin
            sum_reg <= sum_reg + {{(SUM_W-TOT_W){1'b0}}, part};
        end
        if (cmd.term) begin
            term_reg <= (sum_reg >= TWO_Q16) ? (sum_reg - TWO_Q16) : '0;
        end
        if (cmd.acc && last_reg) begin
            odata_reg <= acc_total;
            ouser_reg <= acc_sat;
        end
    end

    assign status.div_done = div_done;
    assign status.last     = last_reg;
    assign status.out_full = ovalid_reg & ~m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

endmodule : skl_dp

`default_nettype wire

// File: rtl/skl_ctrl.sv
// ============================================================================
// skl_ctrl
// Controller: sequences one item through square, four divisions and summing.
// ============================================================================
`default_nettype none

module skl_ctrl
    import skl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire skl_status_t status,
    output skl_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_ABS       = 7'b0000010,
        ST_SQUARE    = 7'b0000100,
        ST_DIV_START = 7'b0001000,
        ST_DIV_WAIT  = 7'b0010000,
        ST_TERM      = 7'b0100000,
        ST_ACC       = 7'b1000000
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ABS;
                end
            end
            ST_ABS: begin
                cmd.take_abs = 1'b1;
                state_next   = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                sel_next   = DIV_R1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.div_take = 1'b1;
                    case (sel_reg)
                        DIV_R1: begin
                            sel_next   = DIV_R2;
                            state_next = ST_DIV_START;
                        end
                        DIV_R2: begin
                            sel_next   = DIV_Q1;
                            state_next = ST_DIV_START;
                        end
                        DIV_Q1: begin
                            sel_next   = DIV_Q2;
                            state_next = ST_DIV_START;
                        end
                        default: begin
                            state_next = ST_TERM;
                        end
                    endcase
                end
            end
            ST_TERM: begin
                cmd.term   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // A closing item waits until the result register is free.
                if (!(status.last && status.out_full)) begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_R1;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule : skl_ctrl

`default_nettype wire

// File: rtl/symmetric_kl_gaussian_distance.sv
// ============================================================================
// symmetric_kl_gaussian_distance
// Accumulates the symmetric KL divergence of two diagonal Gaussians.
// ============================================================================
// Each input item on the s_ channel carries one coefficient: both means and
// both variances in Q16.16, with s_tlast marking the last coefficient of a
// vector. Both variances are raised to the variance floor register, then
// va/vb + vb/va + (ma-mb)^2 * (1/va + 1/vb) - 2 is added to a running total.
// On the last item the total goes out on the m_ channel (Q32.16 in m_tdata,
// the saturation flag in m_tuser) and the total is cleared.
// The block works on one item at a time; s_tready stays low from the
// accepting edge until the total is updated. ABS and SQUARE form the
// squared mean difference, the four quotients share one radix-2 divider
// at one bit per cycle (48 steps for each variance ratio and 64 for each
// squared-difference quotient), and TERM and ACC form the term and update
// the total. A result is shown on m_tvalid in the cycle after the total
// update. The result sits in its own register, so the next item is taken
// while it waits; if the receiver still stalls when the next closing item
// finishes, the block holds that item until the register is free. Reset
// clears the total, the flag, the output and the controller, and sets the
// floor to 10.0. The user must write the floor through the APB port only
// while the block is idle; the block itself does not enforce this.
// ============================================================================
`default_nettype none

module symmetric_kl_gaussian_distance
    import skl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration port; the variance floor sits at byte address 0.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Input items.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [127:0]       s_tdata,  // mean_a, var_a, mean_b, var_b
    input  wire logic               s_tlast,  // last_coeff
    // Result items.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TOT_W-1:0]        m_tdata,  // divergence
    output logic                    m_tuser   // overflowed
);

    skl_cmd_t    cmd;
    skl_status_t status;

    logic [VAL_W-1:0] floor_reg, floor_next;
    logic             cfg_write;

    // The register index is the word address; unknown indexes are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        floor_next = floor_reg;
        if (cfg_write && paddr[2] == REG_VARIANCE_FLOOR) begin
            floor_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
        end else begin
            floor_reg <= floor_next;
        end
    end

    assign prdata = (paddr[2] == REG_VARIANCE_FLOOR) ? floor_reg : '0;

    skl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .floor_val  (floor_reg),
        .mean_a     (s_tdata[31:0]),
        .var_a      (s_tdata[63:32]),
        .mean_b     (s_tdata[95:64]),
        .var_b      (s_tdata[127:96]),
        .last_coeff (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule : symmetric_kl_gaussian_distance

`default_nettype wire

// File: tb/symmetric_kl_gaussian_distance_tb.sv
// ============================================================================
// symmetric_kl_gaussian_distance_tb
// Self-checking testbench of the symmetric KL Gaussian distance block.
// ============================================================================
// Coefficient items are queued by the stimulus process and offered on the s_
// stream by a clocked driver. At each accepted item the driver folds that
// coefficient into a shadow of the running total and, when the item closes a
// vector, queues the divergence the block must report. A clocked monitor
// drives m_tready and checks each accepted result against the oldest queued
// divergence. The variance floor is moved through several settings over the
// APB port, the extremes among them, and read back after every write.
// ============================================================================
`default_nettype none

module symmetric_kl_gaussian_distance_tb;
    import skl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD   = 2;
    localparam int unsigned RESET_CYCLES  = 12;
    // This settle time covers one item that produces no result and is still
    // in flight.
    localparam int unsigned SETTLE_CYCLES = 300;
    // Long enough for the result register to fill and the input to stall.
    localparam int unsigned HOLD_CYCLES   = 3000;

    // Byte addresses on the APB port: paddr[2] selects the register.
    localparam logic [PADDR_W-1:0] ADDR_VARIANCE_FLOOR = {REG_VARIANCE_FLOOR, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED       = {~REG_VARIANCE_FLOOR, 2'b00};

    localparam logic [VAL_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] MEAN_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAR_MAX  = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] Q16_ONE  = 32'h0001_0000;

    // One coefficient: both Gaussians' mean and variance, plus the vector end.
    typedef struct packed {
        logic             last;
        logic [VAL_W-1:0] var_b;
        logic [VAL_W-1:0] mean_b;
        logic [VAL_W-1:0] var_a;
        logic [VAL_W-1:0] mean_a;
    } coeff_t;

    typedef struct packed {
        logic [TOT_W-1:0] divergence;
        logic             overflowed;
    } divergence_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input holds a known value from
    // time zero; the APB signals are only ever driven by the stimulus process.
    // ------------------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [127:0]       s_tdata  = '0;   // mean_a, var_a, mean_b, var_b
    logic               s_tlast  = 1'b0; // last_coeff
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TOT_W-1:0]   m_tdata;         // divergence
    logic               m_tuser;         // overflowed

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    symmetric_kl_gaussian_distance DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Shared bookkeeping.
    // ------------------------------------------------------------------------
    coeff_t           coeff_q[$];        // items waiting to be offered
    divergence_t      divergence_q[$];   // divergences the block still owes
    coeff_t           offered;           // item currently on the s_ channel

    // Shadow of the block's state; the total is updated at every accepted item.
    logic [VAL_W-1:0] floor_shadow    = FLOOR_RESET;
    logic [TOT_W-1:0] total_shadow    = '0;
    logic             overflow_shadow = 1'b0;

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;

    int unsigned errors        = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned overflow_seen = 0;
    int unsigned floor_writes  = 0;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] clip_to_total(logic [63:0] x);
        return (x > 64'(TOTAL_MAX)) ? 64'(TOTAL_MAX) : x;
    endfunction

    // Contribution of one coefficient in Q16.16, before it meets the total.
    // The four quotients are each clipped to the total's width; a sum that
    // truncation left just under 2.0 contributes nothing.
    function automatic logic [63:0] kl_term(coeff_t c, logic [VAL_W-1:0] floor_val);
        logic [63:0]              fl;
        logic [63:0]              va;
        logic [63:0]              vb;
        logic [63:0]              sq;
        logic [63:0]              sum;
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        // A floor of zero still keeps every divisor at one LSB or more.
        fl = (floor_val == '0) ? 64'd1 : 64'(floor_val);
        va = 64'(c.var_a);
        vb = 64'(c.var_b);
        if (va < fl) begin
            va = fl;
        end
        if (vb < fl) begin
            vb = fl;
        end
        diff = $signed({c.mean_a[VAL_W-1], c.mean_a}) - $signed({c.mean_b[VAL_W-1], c.mean_b});
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        sq   = 64'(mag) * 64'(mag);
        sum  = clip_to_total((va << FRAC_W) / vb) + clip_to_total((vb << FRAC_W) / va)
             + clip_to_total(sq / va) + clip_to_total(sq / vb);
        return (sum >= 64'(TWO_Q16)) ? sum - 64'(TWO_Q16) : 64'd0;
    endfunction

    // Adds one accepted coefficient to the shadow total. A closing item
    // queues the divergence the block must report and clears the shadow.
    task automatic fold_coefficient(coeff_t c);
        logic [63:0] term;
        divergence_t owed;
        term = kl_term(c, floor_shadow);
        if (term > 64'(TOTAL_MAX) || 64'(total_shadow) > 64'(TOTAL_MAX) - term) begin
            total_shadow    = TOTAL_MAX;
            overflow_shadow = 1'b1;
        end else begin
            total_shadow = total_shadow + term[TOT_W-1:0];
        end
        if (c.last) begin
            owed.divergence = total_shadow;
            owed.overflowed = overflow_shadow;
            divergence_q.push_back(owed);
            total_shadow    = '0;
            overflow_shadow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued items, holding each one until it is taken. When
    // the channel is free it idles at random according to tx_idle_pct.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fold_coefficient(offered);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (coeff_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered = coeff_q.pop_front();
                    s_tdata  <= {offered.var_b, offered.mean_b, offered.var_a, offered.mean_a};
                    s_tlast  <= offered.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest owed divergence
    // and drives m_tready, either at random or low through a requested hold.
    // ------------------------------------------------------------------------
    task automatic check_result();
        divergence_t owed;
        if (divergence_q.size() == 0) begin
            $error("result with no divergence owed: divergence %0h overflowed %0b",
                   m_tdata, m_tuser);
            errors++;
        end else begin
            owed = divergence_q.pop_front();
            results_seen++;
            if (m_tuser) begin
                overflow_seen++;
            end
            if (m_tdata !== owed.divergence) begin
                $error("divergence mismatch: expected %0h, actual %0h",
                       owed.divergence, m_tdata);
                errors++;
            end
            if (m_tuser !== owed.overflowed) begin
                $error("overflowed mismatch: expected %0b, actual %0b",
                       owed.overflowed, m_tuser);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (hold_requests != holds_served) begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // APB access. The write lands at the edge that closes the access cycle;
    // the read data is sampled at that same edge.
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_VARIANCE_FLOOR) begin
            floor_shadow = data;
            floor_writes++;
        end
    endtask

    task automatic check_floor_readback();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_VARIANCE_FLOOR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== floor_shadow) begin
            $error("variance_floor mismatch: expected %0h, actual %0h", floor_shadow, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_coeff(logic [VAL_W-1:0] mean_a, logic [VAL_W-1:0] var_a,
                               logic [VAL_W-1:0] mean_b, logic [VAL_W-1:0] var_b,
                               logic last);
        coeff_t c;
        c.mean_a = mean_a;
        c.var_a  = var_a;
        c.mean_b = mean_b;
        c.var_b  = var_b;
        c.last   = last;
        coeff_q.push_back(c);
    endtask

    // Full-range means half the time, with small values and the two
    // extremes mixed in so that the squared difference spans its whole range.
    function automatic logic [VAL_W-1:0] random_mean();
        case ($urandom_range(3))
            0, 1:    return $urandom;
            2:       return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(1) ? MEAN_MAX : MEAN_MIN;
        endcase
    endfunction

    // Variances land below, at, just above and far above the current floor.
    function automatic logic [VAL_W-1:0] random_variance();
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return (floor_shadow == '0) ? '0 : $urandom_range(floor_shadow - 1);
            3:       return floor_shadow + $urandom_range(3);
            4:       return floor_shadow + $urandom_range(Q16_ONE * 64);
            default: return $urandom_range(1) ? VAR_MAX : '0;
        endcase
    endfunction

    // Whole vectors of random coefficients: mostly short, sometimes long
    // enough for the total to saturate through accumulation.
    task automatic queue_random_vectors(int unsigned count);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(4, 1);
                6, 7, 8:          len = $urandom_range(12, 5);
                default:          len = $urandom_range(40, 13);
            endcase
            for (int unsigned k = 0; k < len; k++) begin
                queue_coeff(random_mean(), random_variance(), random_mean(),
                            random_variance(), k == len - 1);
            end
            queued += len;
        end
    endtask

    task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
        @(negedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Returns once every queued item is taken and every owed divergence has
    // come back, plus the time one result-free item may still need.
    task automatic wait_drained();
        while (coeff_q.size() != 0 || s_tvalid || divergence_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [VAL_W-1:0] floors [1:5];

        floors[1] = '0;                          // zero, treated as one LSB
        floors[2] = VAR_MAX;                     // every variance raised to max
        floors[3] = 32'd1;                       // smallest nonzero floor
        floors[4] = $urandom_range(32'h00FF_FFFF, 1);
        floors[5] = Q16_ONE;                     // 1.0

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // The floor must come out of reset at 10.0.
        check_floor_readback();

        // Directed coefficients under the reset floor.
        set_idling(37, 55);
        // Everything zero: both variances floored, the term is exactly zero.
        queue_coeff('0, '0, '0, '0, 1'b1);
        // Widest mean difference in both directions, floored and maximal variances.
        queue_coeff(MEAN_MAX, '0, MEAN_MIN, '0, 1'b1);
        queue_coeff(MEAN_MIN, VAR_MAX, MEAN_MAX, VAR_MAX, 1'b1);
        // Most lopsided variance ratio, both ways round.
        queue_coeff(Q16_ONE, VAR_MAX, Q16_ONE, '0, 1'b1);
        queue_coeff('0, '0, '0, VAR_MAX, 1'b1);
        // Variances one LSB apart: truncation leaves the sum just under 2.0.
        queue_coeff(32'h0003_0000, FLOOR_RESET + 1, 32'h0003_0000, FLOOR_RESET, 1'b1);
        // Eight extreme coefficients: the total saturates part way through and
        // the flag must hold until the vector closes.
        for (int unsigned k = 0; k < 8; k++) begin
            queue_coeff(MEAN_MAX, '0, MEAN_MIN, '0, k == 7);
        end
        // The next vector starts clean again.
        queue_coeff(32'hFFFF_0000, 32'h0014_0000, 32'h0001_0000, 32'h000A_0000, 1'b1);
        // A short vector that opens with negative means and moderate values.
        queue_coeff(32'hFFF0_0000, 32'h0020_0000, 32'hFFFF_8000, 32'h0030_0000, 1'b0);
        queue_coeff(32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
        queue_coeff(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        queue_random_vectors(80);
        wait_drained();

        for (int unsigned p = 1; p <= 5; p++) begin
            apb_write(ADDR_VARIANCE_FLOOR, floors[p]);
            check_floor_readback();
            if (p == 3) begin
                // A write to an unmapped address must leave the floor alone.
                apb_write(ADDR_UNMAPPED, $urandom);
                check_floor_readback();
            end

            // Both sides idle in the first phase, roles swap next, and the
            // last phases run with no idling at all.
            if (p < 2) begin
                set_idling(37, 55);
            end else if (p < 4) begin
                set_idling(55, 37);
            end else begin
                set_idling(0, 0);
            end

            if (p == 1) begin
                // Zero floor with zero variances: every divisor is one LSB.
                queue_coeff(Q16_ONE, '0, '0, '0, 1'b1);
                queue_coeff('0, '0, '0, 32'd1, 1'b1);
                queue_coeff(MEAN_MIN, '0, MEAN_MAX, '0, 1'b1);
            end
            if (p == 5) begin
                // The receiver stalls for a long stretch while single-item
                // vectors keep arriving, so the result register fills and the
                // block has to hold off its input.
                hold_requests = hold_requests + 1;
                for (int unsigned k = 0; k < 20; k++) begin
                    queue_coeff(random_mean(), random_variance(), random_mean(),
                                random_variance(), 1'b1);
                end
            end
            queue_random_vectors((p == 5) ? 100 : 105);
            // The sender pauses here until every owed divergence has come.
            wait_drained();
        end

        $display("Covered %0d coefficient items and %0d checked divergences (%0d saturated)",
                 items_taken, results_seen, overflow_seen);
        $display("over %0d variance floor settings with %0d errors", floor_writes + 1, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // A run that has not finished by this bound is stopped and reported as failed.
    initial begin
        #(4_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : symmetric_kl_gaussian_distance_tb

`default_nettype wire

// File: symmetric_kl_gaussian_distance.f
rtl/skl_pkg.sv
rtl/skl_div.sv
rtl/skl_dp.sv
rtl/skl_ctrl.sv
rtl/symmetric_kl_gaussian_distance.sv
tb/symmetric_kl_gaussian_distance_tb.sv
